@@ design/fpcdu_pkg.sv @@
// ----------------------------------------------------------------------------
// fpcdu_pkg
// Shared types, codes and constants of the fax phase C DLE unstuffer.
// ----------------------------------------------------------------------------
package fpcdu_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_ETX     = 2'd0,
        STATUS_TIMEOUT = 2'd1,
        STATUS_CARRIER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_BIT_REVERSE = 2'd0,
        REG_EOL_PAD     = 2'd1,
        REG_CARRIER_CHK = 2'd2,
        REG_ESC_TIMEOUT = 2'd3
    } reg_index_t;

    localparam logic [7:0]  CH_DLE          = 8'h10;
    localparam logic [7:0]  CH_ETX          = 8'h03;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
    localparam logic [15:0] TIMER_MAX       = 16'hFFFF;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
    localparam logic [3:0]  MARKER_IDX      = 4'd9;

    // one pending request's worth of results
    typedef struct packed {
        logic        page_end;
        logic        pad;
        status_t     status;
        logic [7:0]  data;
        logic [31:0] count;
    } job_t;

    function automatic logic [7:0] bit_reverse(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

    // padding sequence 00 08 80, three times
    function automatic logic [7:0] pad_byte(input logic [3:0] idx);
        logic [7:0] r;
        unique case (idx)
            4'd0, 4'd3, 4'd6: r = 8'h00;
            4'd1, 4'd4, 4'd7: r = 8'h08;
            4'd2, 4'd5, 4'd8: r = 8'h80;
            default:          r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ design/fpcdu_rx.sv @@
// ----------------------------------------------------------------------------
// fpcdu_rx
// Receive state, escape timer, byte counter and configuration registers.
// Turns each accepted request into at most one result job.
// ----------------------------------------------------------------------------
module fpcdu_rx (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [fpcdu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               accept,
    input  fpcdu_pkg::cmd_t                    cmd,
    input  logic [7:0]                         rx_byte,
    input  logic                               carrier_present,
    output logic                               job_valid,
    output fpcdu_pkg::job_t                    job
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DATA = 2'd1,
        MODE_ESC  = 2'd2
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] timer_reg, timer_next, timer_inc;
    logic [31:0] total_reg, total_next, total_inc;
    logic        bit_rev_reg, pad_en_reg, carrier_chk_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  mapped;

    assign timer_inc = (timer_reg == fpcdu_pkg::TIMER_MAX) ? timer_reg : timer_reg + 16'd1;
    assign total_inc = (total_reg == fpcdu_pkg::COUNT_MAX) ? total_reg : total_reg + 32'd1;
    assign mapped    = bit_rev_reg ? fpcdu_pkg::bit_reverse(rx_byte) : rx_byte;

    always_comb
    begin
        mode_next    = mode_reg;
        timer_next   = timer_reg;
        total_next   = total_reg;
        job_valid    = 1'b0;
        job.page_end = 1'b0;
        job.pad      = pad_en_reg;
        job.status   = fpcdu_pkg::STATUS_ETX;
        job.data     = mapped;
        job.count    = total_reg;
        if (accept)
        begin
            if (cmd == fpcdu_pkg::CMD_START)
            begin
                mode_next  = MODE_DATA;
                timer_next = '0;
                total_next = '0;
            end
            else if ((cmd == fpcdu_pkg::CMD_BYTE || cmd == fpcdu_pkg::CMD_TICK)
                     && mode_reg != MODE_IDLE)
            begin
                if (carrier_chk_reg && !carrier_present)
                begin
                    mode_next    = MODE_IDLE;
                    timer_next   = '0;
                    job_valid    = 1'b1;
                    job.page_end = 1'b1;
                    job.status   = fpcdu_pkg::STATUS_CARRIER;
                end
                else if (cmd == fpcdu_pkg::CMD_BYTE)
                begin
                    if (mode_reg == MODE_ESC)
                    begin
                        mode_next  = MODE_DATA;
                        timer_next = '0;
                        if (rx_byte == fpcdu_pkg::CH_DLE)
                        begin
                            total_next = total_inc;
                            job_valid  = 1'b1;
                            job.count  = total_inc;
                        end
                        else if (rx_byte == fpcdu_pkg::CH_ETX)
                        begin
                            mode_next    = MODE_IDLE;
                            job_valid    = 1'b1;
                            job.page_end = 1'b1;
                            job.status   = fpcdu_pkg::STATUS_ETX;
                        end
                    end
                    else if (rx_byte == fpcdu_pkg::CH_DLE)
                    begin
                        mode_next  = MODE_ESC;
                        timer_next = '0;
                    end
                    else
                    begin
                        total_next = total_inc;
                        job_valid  = 1'b1;
                        job.count  = total_inc;
                    end
                end
                else if (mode_reg == MODE_ESC)
                begin
                    if (timer_inc >= timeout_reg)
                    begin
                        mode_next    = MODE_IDLE;
                        timer_next   = '0;
                        job_valid    = 1'b1;
                        job.page_end = 1'b1;
                        job.status   = fpcdu_pkg::STATUS_TIMEOUT;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            timer_reg       <= '0;
            total_reg       <= '0;
            bit_rev_reg     <= 1'b1;
            pad_en_reg      <= 1'b0;
            carrier_chk_reg <= 1'b0;
            timeout_reg     <= fpcdu_pkg::TIMEOUT_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            timer_reg <= timer_next;
            total_reg <= total_next;
            if (cfg_we)
            begin
                unique case (fpcdu_pkg::reg_index_t'(cfg_index))
                    fpcdu_pkg::REG_BIT_REVERSE: bit_rev_reg     <= cfg_data[0];
                    fpcdu_pkg::REG_EOL_PAD:     pad_en_reg      <= cfg_data[0];
                    fpcdu_pkg::REG_CARRIER_CHK: carrier_chk_reg <= cfg_data[0];
                    fpcdu_pkg::REG_ESC_TIMEOUT: timeout_reg     <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ design/fax_phase_c_dle_unstuffer_top.sv @@
// ----------------------------------------------------------------------------
// fax_phase_c_dle_unstuffer_top
// Fax phase C receive path: DLE unstuffing, bit reversal, page end handling.
// ----------------------------------------------------------------------------
// One request is taken every cycle while s_axis_tready is high. A data byte's
// result goes through the job and result registers; a page end gives the marker
// alone, or nine padding bytes and the marker, one after another from the result
// register. One request more is held in the job register while a result waits,
// so s_axis_tready drops only when the job register is full and the result
// register does not empty on that cycle (a stalled result or a page end still
// sending). Requests that give no result never occupy the job register.
module fax_phase_c_dle_unstuffer_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [fpcdu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fpcdu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // rx_byte, carrier_present
    input  logic [1:0]                           s_axis_tuser,  // cmd
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fpcdu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // data_out, page_status,
                                                                // page_byte_count
    output logic [1:0]                           m_axis_tuser,  // data_valid, page_done
    output logic                                 m_axis_tlast
);

    logic            accept;
    logic            job_valid;
    fpcdu_pkg::job_t job;

    logic            a_valid_reg;
    fpcdu_pkg::job_t a_job_reg;
    logic            b_valid_reg;
    fpcdu_pkg::job_t b_job_reg;
    logic [3:0]      b_idx_reg;

    logic            b_free, a_move, b_take, b_last;
    logic            is_marker;
    logic [7:0]      out_data;
    logic [1:0]      out_status;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_marker     = b_job_reg.page_end && (b_idx_reg == fpcdu_pkg::MARKER_IDX);
    assign b_last        = !b_job_reg.page_end || is_marker;
    assign b_take        = b_valid_reg && m_axis_tready;
    assign b_free        = !b_valid_reg || (b_take && b_last);
    assign a_move        = a_valid_reg && b_free;
    assign s_axis_tready = !a_valid_reg || b_free;

    fpcdu_rx u_rx (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .accept          (accept),
        .cmd             (fpcdu_pkg::cmd_t'(s_axis_tuser)),
        .rx_byte         (s_axis_tdata[7:0]),
        .carrier_present (s_axis_tdata[8]),
        .job_valid       (job_valid),
        .job             (job)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && job_valid)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;

            if (a_move)
                b_valid_reg <= 1'b1;
            else if (b_take && b_last)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && job_valid)
            a_job_reg <= job;
        if (a_move)
        begin
            b_job_reg <= a_job_reg;
            b_idx_reg <= (a_job_reg.page_end && a_job_reg.pad) ? 4'd0 : fpcdu_pkg::MARKER_IDX;
        end
        else if (b_take && !b_last)
        begin
            b_idx_reg <= b_idx_reg + 4'd1;
        end
    end

    always_comb
    begin
        if (!b_job_reg.page_end)
            out_data = b_job_reg.data;
        else if (is_marker)
            out_data = 8'h00;
        else
            out_data = fpcdu_pkg::pad_byte(b_idx_reg);
    end

    assign out_status    = is_marker ? b_job_reg.status : fpcdu_pkg::STATUS_ETX;
    assign m_axis_tvalid = b_valid_reg;
    assign m_axis_tdata  = {6'd0, b_job_reg.count, out_status, out_data};
    assign m_axis_tuser  = {is_marker, !is_marker};
    assign m_axis_tlast  = b_last;

endmodule

@@ design/fpcdu_checker.sv @@
// ----------------------------------------------------------------------------
// fpcdu_checker
// Port-level checks of the DLE unstuffer result stream.
// ----------------------------------------------------------------------------
module fpcdu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // marker closes the request's results
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("page marker without tlast");

    // marker carries no byte
    a_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tdata[7:0] == 8'h00)
        else $error("page marker carries data");

    // status only on the marker
    a_status_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[9:8] == 2'd0 && m_axis_tuser[0])
        else $error("status on non-marker result");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind fax_phase_c_dle_unstuffer_top fpcdu_checker u_fpcdu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
